// File: hdl/point_in_polygon_crossing_assert.svh
// ----------------------------------------------------------------------------
// point in polygon assertion macros
// shorthand for the concurrent checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_CROSSING_ASSERT_SVH
`define POINT_IN_POLYGON_CROSSING_ASSERT_SVH

// same-cycle implication on the block clock, held off during reset
`define PPIC_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("point in polygon check failed");

// next-cycle implication on the block clock, held off during reset
`define PPIC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("point in polygon check failed");

`endif

// File: hdl/ppic_pkg.sv
// ----------------------------------------------------------------------------
// ppic_pkg
// shared types and constants of the point in polygon crossing block
// ----------------------------------------------------------------------------
package ppic_pkg;

   localparam int COORD_BITS_DEFAULT = 24;
   localparam int COUNT_BITS_DEFAULT = 12;
   localparam int QUEUE_DEPTH        = 4;
   localparam int VERDICT_BITS       = 2;

   typedef enum logic [VERDICT_BITS-1:0] {
      VERDICT_OUTSIDE    = 2'd0,
      VERDICT_INSIDE     = 2'd1,
      VERDICT_DEGENERATE = 2'd2
   } verdict_type;

   typedef struct packed {
      logic first;
      logic last;
      logic on_line;
      logic same_side;
   } edge_flags_type;

endpackage

// File: hdl/ppic_fifo.sv
// ----------------------------------------------------------------------------
// ppic_fifo
// small first-in first-out queue of words with full and empty flags
// ----------------------------------------------------------------------------
module ppic_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = ppic_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == CNT_BITS'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: hdl/ppic_front.sv
// ----------------------------------------------------------------------------
// ppic_front
// latches the test point, keeps the previous vertex and classifies each edge
// ----------------------------------------------------------------------------
module ppic_front #(
   parameter int COORD_BITS = ppic_pkg::COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic signed [COORD_BITS-1:0] test_x,
   input  logic signed [COORD_BITS-1:0] test_y,
   input  logic signed [COORD_BITS-1:0] vert_x,
   input  logic signed [COORD_BITS-1:0] vert_y,
   input  logic                         first_vertex,
   input  logic                         last_vertex,
   output ppic_pkg::edge_flags_type     flags,
   output logic signed [COORD_BITS:0]   diff_a,
   output logic signed [COORD_BITS:0]   diff_b,
   output logic signed [COORD_BITS:0]   diff_c,
   output logic signed [COORD_BITS:0]   diff_d
);

   logic signed [COORD_BITS-1:0] prev_vx_ff, prev_vy_ff;
   logic signed [COORD_BITS-1:0] held_px_ff, held_py_ff;
   logic signed [COORD_BITS:0]   vx_w, vy_w, pvx_w, pvy_w, hpx_w, hpy_w;

   always_comb begin
      vx_w  = {vert_x[COORD_BITS-1], vert_x};
      vy_w  = {vert_y[COORD_BITS-1], vert_y};
      pvx_w = {prev_vx_ff[COORD_BITS-1], prev_vx_ff};
      pvy_w = {prev_vy_ff[COORD_BITS-1], prev_vy_ff};
      hpx_w = {held_px_ff[COORD_BITS-1], held_px_ff};
      hpy_w = {held_py_ff[COORD_BITS-1], held_py_ff};

      flags.first     = first_vertex;
      flags.last      = last_vertex;
      flags.on_line   = (held_py_ff == vert_y) || (held_py_ff == prev_vy_ff);
      flags.same_side = ((vert_y > held_py_ff) && (prev_vy_ff > held_py_ff)) ||
                        ((vert_y < held_py_ff) && (prev_vy_ff < held_py_ff));

      // edge from this vertex back to the previous one
      diff_a = pvx_w - vx_w;
      diff_b = hpy_w - vy_w;
      diff_c = vx_w - hpx_w;
      diff_d = pvy_w - vy_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_vx_ff <= '0;
         prev_vy_ff <= '0;
         held_px_ff <= '0;
         held_py_ff <= '0;
      end else if (accept) begin
         prev_vx_ff <= vert_x;
         prev_vy_ff <= vert_y;
         if (first_vertex) begin
            held_px_ff <= test_x;
            held_py_ff <= test_y;
         end
      end
   end

endmodule

// File: hdl/ppic_back.sv
// ----------------------------------------------------------------------------
// ppic_back
// exact crossing test by cross products, crossing count and verdict
// ----------------------------------------------------------------------------
module ppic_back #(
   parameter int COORD_BITS = ppic_pkg::COORD_BITS_DEFAULT,
   parameter int COUNT_BITS = ppic_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_pop,
   input  ppic_pkg::edge_flags_type   in_flags,
   input  logic signed [COORD_BITS:0] diff_a,
   input  logic signed [COORD_BITS:0] diff_b,
   input  logic signed [COORD_BITS:0] diff_c,
   input  logic signed [COORD_BITS:0] diff_d,
   input  logic                       out_full,
   output logic                       out_push,
   output ppic_pkg::verdict_type      out_verdict,
   output logic [COUNT_BITS-1:0]      out_count
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 1;

   logic                     advance;
   logic signed [PW-1:0]     prod_ab_in, prod_cd_in;

   logic                     s1_valid_ff;
   ppic_pkg::edge_flags_type s1_flags_ff;
   logic signed [PW-1:0]     s1_prod_ab_ff, s1_prod_cd_ff;
   logic                     s1_dneg_ff;

   logic [SW-1:0]            cross_sum;
   logic                     sum_zero, edge_degen, edge_cross, emit;

   logic [COUNT_BITS-1:0]    cnt_ff, cnt_mid, cnt_in;
   logic                     par_ff, par_mid, par_in;
   logic                     deg_ff, deg_mid, deg_in;

   assign advance    = ~out_full;
   assign in_pop     = advance & in_valid;
   assign prod_ab_in = diff_a * diff_b;
   assign prod_cd_in = diff_c * diff_d;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_flags_ff   <= in_flags;
         s1_prod_ab_ff <= prod_ab_in;
         s1_prod_cd_ff <= prod_cd_in;
         s1_dneg_ff    <= diff_d[DW-1];
      end
   end

   always_comb begin
      cross_sum  = {s1_prod_ab_ff[PW-1], s1_prod_ab_ff} +
                   {s1_prod_cd_ff[PW-1], s1_prod_cd_ff};
      sum_zero   = (cross_sum == '0);
      edge_degen = s1_flags_ff.on_line | (~s1_flags_ff.same_side & sum_zero);
      edge_cross = ~s1_flags_ff.on_line & ~s1_flags_ff.same_side & ~sum_zero &
                   (cross_sum[SW-1] == s1_dneg_ff);

      cnt_mid = cnt_ff;
      par_mid = par_ff;
      deg_mid = deg_ff;
      if (s1_flags_ff.first) begin
         cnt_mid = '0;
         par_mid = 1'b0;
         deg_mid = 1'b0;
      end else if (edge_degen) begin
         deg_mid = 1'b1;
      end else if (edge_cross) begin
         par_mid = ~par_ff;
         if (cnt_ff != '1) begin
            cnt_mid = cnt_ff + 1'b1;
         end
      end

      emit     = s1_valid_ff & s1_flags_ff.last;
      out_push = advance & emit;

      if (deg_mid) begin
         out_verdict = ppic_pkg::VERDICT_DEGENERATE;
         out_count   = '0;
      end else begin
         out_verdict = par_mid ? ppic_pkg::VERDICT_INSIDE : ppic_pkg::VERDICT_OUTSIDE;
         out_count   = cnt_mid;
      end

      // totals restart once the verdict has gone
      cnt_in = emit ? '0 : cnt_mid;
      par_in = emit ? 1'b0 : par_mid;
      deg_in = emit ? 1'b0 : deg_mid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         par_ff <= 1'b0;
         deg_ff <= 1'b0;
      end else if (advance && s1_valid_ff) begin
         cnt_ff <= cnt_in;
         par_ff <= par_in;
         deg_ff <= deg_in;
      end
   end

endmodule

// File: hdl/point_in_polygon_crossing.sv
// path: an accepted vertex word is written into the edge queue, then its products into the
// back end register, and the verdict of a closing vertex then into the result queue
// throughput: one vertex per cycle, set by the multiply stage, while neither queue is full
// reset: synchronous and active high; clears queues, totals and the stored point and vertex
// ----------------------------------------------------------------------------
// point_in_polygon_crossing
// crossing number point in polygon test: front classifier, edge queue,
// cross product back end and result queue
// ----------------------------------------------------------------------------
`include "point_in_polygon_crossing_assert.svh"

module point_in_polygon_crossing #(
   parameter int COORD_BITS = ppic_pkg::COORD_BITS_DEFAULT,
   parameter int COUNT_BITS = ppic_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic signed [COORD_BITS-1:0] req_test_x,
   input  logic signed [COORD_BITS-1:0] req_test_y,
   input  logic signed [COORD_BITS-1:0] req_vert_x,
   input  logic signed [COORD_BITS-1:0] req_vert_y,
   input  logic                         req_first_vertex,
   input  logic                         req_last_vertex,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [1:0]                   rsp_verdict,
   output logic [COUNT_BITS-1:0]        rsp_crossing_count
);

   localparam int DW        = COORD_BITS + 1;
   localparam int FLAG_BITS = $bits(ppic_pkg::edge_flags_type);
   localparam int MID_BITS  = FLAG_BITS + 4 * DW;
   localparam int RSP_BITS  = ppic_pkg::VERDICT_BITS + COUNT_BITS;

   logic                     accept;
   ppic_pkg::edge_flags_type front_flags, back_flags;
   logic signed [DW-1:0]     front_a, front_b, front_c, front_d;
   logic signed [DW-1:0]     back_a, back_b, back_c, back_d;
   logic [MID_BITS-1:0]      mid_wr, mid_rd;
   logic                     mid_full, mid_empty, mid_pop;
   logic                     out_full, out_push;
   ppic_pkg::verdict_type    out_verdict;
   logic [COUNT_BITS-1:0]    out_count;
   logic [RSP_BITS-1:0]      rsp_wr, rsp_rd;
   logic                     rsp_degen, rsp_inside, rsp_sat;

   assign accept   = req_push & ~mid_full;
   assign req_full = mid_full;

   ppic_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .test_x      (req_test_x),
      .test_y      (req_test_y),
      .vert_x      (req_vert_x),
      .vert_y      (req_vert_y),
      .first_vertex(req_first_vertex),
      .last_vertex (req_last_vertex),
      .flags       (front_flags),
      .diff_a      (front_a),
      .diff_b      (front_b),
      .diff_c      (front_c),
      .diff_d      (front_d)
   );

   assign mid_wr = {front_flags, front_a, front_b, front_c, front_d};

   ppic_fifo #(
      .WIDTH(MID_BITS),
      .DEPTH(ppic_pkg::QUEUE_DEPTH)
   ) u_edge_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (req_push),
      .wr_data(mid_wr),
      .full   (mid_full),
      .pop    (mid_pop),
      .rd_data(mid_rd),
      .empty  (mid_empty)
   );

   assign back_flags = ppic_pkg::edge_flags_type'(mid_rd[MID_BITS-1 -: FLAG_BITS]);
   assign back_a     = mid_rd[4*DW-1 -: DW];
   assign back_b     = mid_rd[3*DW-1 -: DW];
   assign back_c     = mid_rd[2*DW-1 -: DW];
   assign back_d     = mid_rd[DW-1:0];

   ppic_back #(
      .COORD_BITS(COORD_BITS),
      .COUNT_BITS(COUNT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (~mid_empty),
      .in_pop     (mid_pop),
      .in_flags   (back_flags),
      .diff_a     (back_a),
      .diff_b     (back_b),
      .diff_c     (back_c),
      .diff_d     (back_d),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_verdict(out_verdict),
      .out_count  (out_count)
   );

   assign rsp_wr = {out_verdict, out_count};

   ppic_fifo #(
      .WIDTH(RSP_BITS),
      .DEPTH(ppic_pkg::QUEUE_DEPTH)
   ) u_result_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (out_push),
      .wr_data(rsp_wr),
      .full   (out_full),
      .pop    (rsp_pop),
      .rd_data(rsp_rd),
      .empty  (rsp_empty)
   );

   assign rsp_verdict        = rsp_rd[RSP_BITS-1 -: ppic_pkg::VERDICT_BITS];
   assign rsp_crossing_count = rsp_rd[COUNT_BITS-1:0];

   assign rsp_degen  = (rsp_verdict == ppic_pkg::VERDICT_DEGENERATE);
   assign rsp_inside = (rsp_verdict == ppic_pkg::VERDICT_INSIDE);
   assign rsp_sat    = (rsp_crossing_count == '1);

   // degenerate polygons report no crossings
   `PPIC_ASSERT_IMPLY(a_degen_count_zero, !rsp_empty && rsp_degen, rsp_crossing_count == '0)
   // below saturation the count parity matches the verdict
   `PPIC_ASSERT_IMPLY(a_parity_matches, !rsp_empty && !rsp_sat, rsp_crossing_count[0] == rsp_inside)
   // an accepted word is waiting in the edge queue on the next cycle
   `PPIC_ASSERT_NEXT(a_word_queued, req_push && !req_full, !mid_empty)

endmodule
